// File: hdl/bsid_pkg.sv
// shared types and constants for the branch and system instruction decoder
`default_nettype none

package bsid_pkg;

	localparam int INSN_W   = 32;
	localparam int OFFSET_W = 25;
	localparam int MASK_W   = 9;
	localparam int IMM_W    = 9;
	localparam int REG_W    = 4;
	localparam int COND_W   = 4;
	localparam int TDATA_W  = 56;
	localparam int TUSER_W  = 5;

	localparam logic [COND_W-1:0] COND_AL  = 4'd14;
	localparam logic [REG_W-1:0]  REG_SP   = 4'd13;
	localparam logic [REG_W-1:0]  REG_LR   = 4'd14;
	localparam logic [REG_W-1:0]  REG_PC   = 4'd15;
	localparam logic [3:0]        NIB_ONES = 4'hF;
	localparam logic [7:0]        HINT_WFI = 8'h03;

	localparam logic [2:0] SYS_MSR      = 3'd0;
	localparam logic [2:0] SYS_MSR_SPSR = 3'd1;
	localparam logic [2:0] SYS_HINT     = 3'd2;
	localparam logic [2:0] SYS_CTRL     = 3'd3;
	localparam logic [2:0] SYS_BXJ      = 3'd4;
	localparam logic [2:0] SYS_ERET     = 3'd5;
	localparam logic [2:0] SYS_SMC      = 3'd7;

	typedef enum logic [3:0] {
		CLS_B      = 4'd0,
		CLS_BL     = 4'd1,
		CLS_BLX    = 4'd2,
		CLS_MSR    = 4'd3,
		CLS_MRS    = 4'd4,
		CLS_CPS    = 4'd5,
		CLS_WFI    = 4'd6,
		CLS_NOP    = 4'd7,
		CLS_CLREX  = 4'd8,
		CLS_ERET   = 4'd9,
		CLS_UNIMP  = 4'd10
	} op_class_t;

	typedef enum logic [3:0] {
		CTL_LEAVEX = 4'd0,
		CTL_ENTERX = 4'd1,
		CTL_CLREX  = 4'd2,
		CTL_DSB    = 4'd4,
		CTL_DMB    = 4'd5,
		CTL_ISB    = 4'd6
	} ctl_op_t;

	typedef struct packed {
		logic                       accepted;
		op_class_t                  op_class;
		logic [COND_W-1:0]          cond_code;
		logic signed [OFFSET_W-1:0] branch_offset;
		logic                       writes_pc;
		logic                       ctx_sync;
		logic                       undef_in_it;
		logic                       spsr_select;
		logic [REG_W-1:0]           reg_num;
		logic [MASK_W-1:0]          field_mask;
		logic [IMM_W-1:0]           immediate;
	} dec_res_t;

	localparam dec_res_t RES_NONE = '{
		accepted:      1'b0,
		op_class:      CLS_B,
		cond_code:     COND_AL,
		branch_offset: '0,
		writes_pc:     1'b0,
		ctx_sync:      1'b0,
		undef_in_it:   1'b0,
		spsr_select:   1'b0,
		reg_num:       '0,
		field_mask:    '0,
		immediate:     '0
	};

endpackage

`default_nettype wire

// File: hdl/bsid_decode.sv
// combinational decode of one thumb-2 branch or system-control word
`default_nettype none

module bsid_decode
	import bsid_pkg::*;
(
	input  wire logic [INSN_W-1:0] insn,
	output dec_res_t               res
);

	logic                sgn;
	logic                i1;
	logic                i2;
	logic [OFFSET_W-1:0] off_long;
	logic [OFFSET_W-1:0] off_long2;
	logic [OFFSET_W-1:0] off_cond;
	logic [2:0]          sel;
	logic                misc_ok;
	logic [1:0]          imod;
	logic                cps_m;
	logic [2:0]          aif;
	logic [4:0]          mode;
	logic [REG_W-1:0]    rn;
	logic [REG_W-1:0]    rd;
	dec_res_t            d;

	assign sgn = insn[26];
	assign i1  = ~(insn[13] ^ sgn);
	assign i2  = ~(insn[11] ^ sgn);
	assign off_long  = {sgn, i1, i2, insn[25:16], insn[10:0], 1'b0};
	assign off_long2 = {sgn, i1, i2, insn[25:16], insn[10:1], 2'b00};
	assign off_cond  = {{4{sgn}}, sgn, insn[11], insn[13], insn[21:16], insn[10:0], 1'b0};

	assign sel     = insn[22:20];
	assign misc_ok = (insn[19:16] == NIB_ONES) && !insn[13] && (insn[11:8] == NIB_ONES);
	assign imod    = insn[10:9];
	assign cps_m   = insn[8];
	assign aif     = insn[7:5];
	assign mode    = insn[4:0];
	assign rn      = insn[19:16];
	assign rd      = insn[11:8];

	always_comb begin
		d = RES_NONE;
		if (insn[14] && insn[12]) begin
			d.accepted      = 1'b1;
			d.op_class      = CLS_BL;
			d.branch_offset = off_long;
			d.writes_pc     = 1'b1;
		end else if (insn[14]) begin
			if (!insn[0]) begin
				d.accepted      = 1'b1;
				d.op_class      = CLS_BLX;
				d.branch_offset = off_long2;
				d.writes_pc     = 1'b1;
			end
		end else if (insn[12]) begin
			d.accepted      = 1'b1;
			d.op_class      = CLS_B;
			d.branch_offset = off_long;
			d.writes_pc     = 1'b1;
		end else if (insn[25:23] != 3'b111) begin
			// conditional branch
			d.accepted      = 1'b1;
			d.op_class      = CLS_B;
			d.cond_code     = insn[25:22];
			d.branch_offset = off_cond;
			d.writes_pc     = 1'b1;
		end else if (!insn[26]) begin
			case (sel)
				SYS_MSR, SYS_MSR_SPSR: begin
					if (!insn[13] && (insn[7:0] == 8'd0) && (rn != REG_SP) && (rn != REG_PC)) begin
						d.accepted     = 1'b1;
						d.op_class     = CLS_MSR;
						d.spsr_select  = insn[20];
						d.reg_num      = rn;
						d.field_mask   = {5'd0, insn[11:8]};
						d.ctx_sync     = 1'b1;
					end
				end
				SYS_HINT: begin
					if ((rn == NIB_ONES) && !insn[13] && !insn[11]) begin
						if (insn[10:8] == 3'd0) begin
							d.accepted = 1'b1;
							d.op_class = (insn[7:0] == HINT_WFI) ? CLS_WFI : CLS_NOP;
						end else if (!((mode != 5'd0) && !cps_m) &&
							(imod[1] == (aif != 3'd0)) && (imod != 2'd1)) begin
							d.accepted     = 1'b1;
							d.op_class     = CLS_CPS;
							d.field_mask   = {aif, 1'b0, {5{cps_m}}};
							d.immediate    = {((imod == 2'd3) ? aif : 3'd0), 1'b0,
								(cps_m ? mode : 5'd0)};
							d.undef_in_it  = 1'b1;
							d.ctx_sync     = 1'b1;
						end
					end
				end
				SYS_CTRL: begin
					case (insn[7:4])
						CTL_LEAVEX: begin
							if (misc_ok && (insn[3:0] == NIB_ONES)) begin
								d.accepted    = 1'b1;
								d.op_class    = CLS_NOP;
								d.undef_in_it = 1'b1;
							end
						end
						CTL_ENTERX: begin
							d.accepted = 1'b1;
							d.op_class = CLS_UNIMP;
						end
						CTL_CLREX: begin
							if (misc_ok && (insn[3:0] == NIB_ONES)) begin
								d.accepted = 1'b1;
								d.op_class = CLS_CLREX;
							end
						end
						CTL_DSB, CTL_DMB: begin
							if (misc_ok) begin
								d.accepted = 1'b1;
								d.op_class = CLS_NOP;
							end
						end
						CTL_ISB: begin
							if (misc_ok) begin
								d.accepted = 1'b1;
								d.op_class = CLS_NOP;
								d.ctx_sync = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				SYS_BXJ: begin
					d.accepted = 1'b1;
					d.op_class = CLS_UNIMP;
				end
				SYS_ERET: begin
					if ((rn == REG_LR) && !insn[13] && (rd == NIB_ONES)) begin
						d.accepted  = 1'b1;
						d.op_class  = CLS_ERET;
						d.reg_num   = REG_LR;
						d.immediate = {1'b0, insn[7:0]};
						d.writes_pc = 1'b1;
					end
				end
				default: begin
					if ((rn == NIB_ONES) && !insn[13] && (insn[7:0] == 8'd0) &&
						(rd != REG_SP) && (rd != REG_PC)) begin
						d.accepted    = 1'b1;
						d.op_class    = CLS_MRS;
						d.spsr_select = insn[20];
						d.reg_num     = rd;
					end
				end
			endcase
		end else if ((insn[14:12] == 3'd0) && (sel == SYS_SMC)) begin
			d.accepted = 1'b1;
			d.op_class = CLS_UNIMP;
		end
		res = d.accepted ? d : RES_NONE;
	end

endmodule

`default_nettype wire

// File: hdl/branch_system_insn_decode_core.sv
// top level: registered thumb-2 branch and system-control decoder
//
// s_tdata carries one 32-bit instruction word per beat, first halfword in
// bits 31..16. each accepted word yields exactly one result beat on the m
// side, in order. m_tuser says whether the word decoded and its class;
// m_tdata holds the operands. rejected words give accepted = 0 with all
// operand fields zero and condition 14.
// each word passes through an input register, one level of decode logic, and a
// result register. throughput is one beat per cycle while m_tready stays high;
// the decode has no loop or shared unit.
// when the receiver stalls, the result register holds its beat and the
// input register can still take one more word, after which s_tready drops
// until the result is taken.
// reset empties both registers; nothing else is held.
`default_nettype none

module branch_system_insn_decode_core
	import bsid_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [INSN_W-1:0]  s_tdata,   // instruction[31:0]
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // cond_code[3:0], branch_offset[28:4],
	                                           // writes_pc[29], ctx_sync[30],
	                                           // undef_in_it[31], spsr_select[32],
	                                           // reg_num[36:33], field_mask[45:37],
	                                           // immediate[54:46], zero[55]
	output logic [TUSER_W-1:0]      m_tuser    // accepted[0], op_class[4:1]
);

	logic              valid_s1;
	logic [INSN_W-1:0] insn_s1;
	logic              valid_s2;
	dec_res_t          res_s2;
	dec_res_t          dec_res;
	logic              load_s2;
	logic              load_s1;

	bsid_decode u_decode (
		.insn (insn_s1),
		.res  (dec_res)
	);

	assign load_s2  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			insn_s1 <= s_tdata;
		if (load_s2 && valid_s1)
			res_s2 <= dec_res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = {res_s2.op_class, res_s2.accepted};
	assign m_tdata  = {1'b0, res_s2.immediate, res_s2.field_mask, res_s2.reg_num,
		res_s2.spsr_select, res_s2.undef_in_it, res_s2.ctx_sync,
		res_s2.writes_pc, res_s2.branch_offset, res_s2.cond_code};

`ifndef SYNTH
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.accepted |-> res_s2 == RES_NONE)
		else $error("rejected result carries nonzero fields");

	a_cond_only_branch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.op_class != CLS_B) |-> res_s2.cond_code == COND_AL)
		else $error("condition set on a non-branch result");

	a_pc_write_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.writes_pc |-> res_s2.op_class == CLS_B ||
		res_s2.op_class == CLS_BL || res_s2.op_class == CLS_BLX ||
		res_s2.op_class == CLS_ERET)
		else $error("pc write flagged on a class that does not branch");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(insn_s1))
		else $error("input register lost a word while the result register was full");
`endif

endmodule

`default_nettype wire
